FILE: hw/rtl/integer_to_ascii_radix_macros.svh
// assertion helpers used by the block's top-level file
`ifndef INTEGER_TO_ASCII_RADIX_MACROS_SVH
`define INTEGER_TO_ASCII_RADIX_MACROS_SVH

// same-cycle implication, sampled on the rising edge of clk
`define ITAR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on the rising edge of clk
`define ITAR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/itar_pkg.sv
package itar_pkg;

    localparam int RADIX_BITS         = 6;
    localparam int CHAR_BITS          = 8;
    localparam int DIV_BITS_PER_CYCLE = 8;

    localparam logic [CHAR_BITS-1:0]  CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_BITS-1:0]  CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_BITS-1:0]  CHAR_MINUS   = 8'h2d;
    localparam logic [RADIX_BITS-1:0] RADIX_MIN    = 6'd2;
    localparam logic [RADIX_BITS-1:0] RADIX_MAX    = 6'd36;
    localparam logic [RADIX_BITS-1:0] DIGIT_TEN    = 6'd10;

    typedef struct packed {
        logic [RADIX_BITS-1:0] radix;
        logic                  neg;
    } item_ctl_t;

    typedef struct packed {
        logic                  start;
        logic [RADIX_BITS-1:0] divisor;
    } div_req_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_DIV,
        B_FETCH,
        B_SIGN,
        B_EMIT
    } back_state_t;

    function automatic logic [CHAR_BITS-1:0] digit_char(input logic [RADIX_BITS-1:0] d);
        logic [CHAR_BITS-1:0] c;
        if (d >= DIGIT_TEN)
        begin
            c = CHAR_LOWER_A + CHAR_BITS'(d - DIGIT_TEN);
        end
        else
        begin
            c = CHAR_ZERO + CHAR_BITS'(d);
        end
        return c;
    endfunction

endpackage

FILE: hw/rtl/itar_ram.sv
module itar_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/itar_fifo.sv
module itar_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int DEPTH    = 2;
    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    mem_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                do_push, do_pop;

    assign full     = (count_reg == CNT_BITS'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: hw/rtl/itar_front.sv
module itar_front #(
    parameter int VALUE_BITS = 32
) (
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [VALUE_BITS-1:0]           value,
    input  logic [itar_pkg::RADIX_BITS-1:0] radix,
    input  logic                            signed_mode,
    input  logic                            full,
    output logic                            push,
    output logic [VALUE_BITS-1:0]           magnitude,
    output itar_pkg::item_ctl_t             ctl
);

    import itar_pkg::*;

    logic neg;

    assign in_ready = !full;
    assign push     = in_valid && !full;
    assign neg      = signed_mode && value[VALUE_BITS-1];

    // most negative value wraps back to itself, which is its unsigned magnitude
    assign magnitude = neg ? (~value + 1'b1) : value;

    always_comb
    begin
        ctl.neg = neg;
        if (radix < RADIX_MIN)
        begin
            ctl.radix = RADIX_MIN;
        end
        else if (radix > RADIX_MAX)
        begin
            ctl.radix = RADIX_MAX;
        end
        else
        begin
            ctl.radix = radix;
        end
    end

endmodule

FILE: hw/rtl/itar_div.sv
module itar_div #(
    parameter int VALUE_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  itar_pkg::div_req_t              req,
    input  logic [VALUE_BITS-1:0]           dividend,
    output logic                            done,
    output logic [VALUE_BITS-1:0]           quotient,
    output logic [itar_pkg::RADIX_BITS-1:0] remainder
);

    import itar_pkg::*;

    localparam int STEP     = DIV_BITS_PER_CYCLE;
    localparam int CYCLES   = (VALUE_BITS + STEP - 1) / STEP;
    localparam int PAD      = CYCLES * STEP;
    localparam int CNT_BITS = $clog2(CYCLES + 1);

    logic [PAD-1:0]        work_reg, work_next;
    logic [RADIX_BITS-1:0] rem_reg, rem_next;
    logic [RADIX_BITS-1:0] divisor_reg;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    // restoring division, several quotient bits per cycle
    always_comb
    begin
        logic [RADIX_BITS:0] t;
        work_next = work_reg;
        rem_next  = rem_reg;
        for (int i = 0; i < STEP; i++)
        begin
            t         = {rem_next, work_next[PAD-1]};
            work_next = {work_next[PAD-2:0], 1'b0};
            if (t >= {1'b0, divisor_reg})
            begin
                t            = t - {1'b0, divisor_reg};
                work_next[0] = 1'b1;
            end
            rem_next = t[RADIX_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(CYCLES);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            work_reg    <= PAD'(dividend);
            rem_reg     <= '0;
            divisor_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = work_reg[VALUE_BITS-1:0];
    assign remainder = rem_reg;

endmodule

FILE: hw/rtl/itar_back.sv
module itar_back #(
    parameter int VALUE_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            empty,
    output logic                            pop,
    input  logic [VALUE_BITS-1:0]           magnitude,
    input  itar_pkg::item_ctl_t             ctl,
    output itar_pkg::div_req_t              div_req,
    output logic [VALUE_BITS-1:0]           div_dividend,
    input  logic                            div_done,
    input  logic [VALUE_BITS-1:0]           div_quotient,
    input  logic [itar_pkg::RADIX_BITS-1:0] div_remainder,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [itar_pkg::CHAR_BITS-1:0]  out_char,
    output logic                            out_last
);

    import itar_pkg::*;

    localparam int DEPTH     = VALUE_BITS;
    localparam int ADDR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS  = $clog2(DEPTH + 1);

    back_state_t           state_reg, state_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic [RADIX_BITS-1:0] radix_reg, radix_next;
    logic                  neg_reg, neg_next;
    logic                  out_valid_reg, out_valid_next;
    logic [CHAR_BITS-1:0]  out_char_reg, out_char_next;
    logic                  out_last_reg, out_last_next;
    logic                  slot_free;
    logic                  wr_en;
    logic [ADDR_BITS-1:0]  rd_addr;
    logic [RADIX_BITS-1:0] rd_data;

    // digits come out least significant first, so they are stacked and read back
    itar_ram #(
        .WIDTH (RADIX_BITS),
        .DEPTH (DEPTH)
    ) u_digit_stack (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[ADDR_BITS-1:0]),
        .wr_data (div_remainder),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign slot_free = !out_valid_reg || out_ready;
    // read one ahead so the top of the stack is ready in the next cycle
    assign rd_addr   = ADDR_BITS'(count_next - CNT_BITS'(1));

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        radix_next      = radix_reg;
        neg_next        = neg_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_char_next   = out_char_reg;
        out_last_next   = out_last_reg;
        pop             = 1'b0;
        wr_en           = 1'b0;
        div_req.start   = 1'b0;
        div_req.divisor = radix_reg;
        div_dividend    = div_quotient;
        case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                begin
                    pop             = 1'b1;
                    div_req.start   = 1'b1;
                    div_req.divisor = ctl.radix;
                    div_dividend    = magnitude;
                    radix_next      = ctl.radix;
                    neg_next        = ctl.neg;
                    count_next      = '0;
                    state_next      = B_DIV;
                end
            end
            B_DIV:
            begin
                if (div_done)
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                    if (div_quotient == '0)
                    begin
                        state_next = B_FETCH;
                    end
                    else
                    begin
                        div_req.start = 1'b1;
                    end
                end
            end
            B_FETCH:
            begin
                state_next = neg_reg ? B_SIGN : B_EMIT;
            end
            B_SIGN:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = CHAR_MINUS;
                    out_last_next  = 1'b0;
                    state_next     = B_EMIT;
                end
            end
            B_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = digit_char(rd_data);
                    out_last_next  = (count_reg == CNT_BITS'(1));
                    count_next     = count_reg - 1'b1;
                    if (count_reg == CNT_BITS'(1))
                    begin
                        state_next = B_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        radix_reg    <= radix_next;
        neg_reg      <= neg_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;

endmodule

FILE: hw/rtl/integer_to_ascii_radix.sv
// Integer to ASCII text in radix 2 to 36.
// Input stream (s_axis): one beat per number; value, radix and the signed-mode
// flag. A radix below 2 is taken as 2, one above 36 as 36.
// Output stream (m_axis): one beat per character, most significant first, a
// leading '-' for a negative signed value, tlast on the final character.
// Sequence: for each digit the iterative divider loads its operands, then
// works through the dividend eight bits at a time. The digits go onto a
// stack; after a stack turnaround the back end sends a '-' when the value is
// negative, then the characters, each as soon as the output slot is free.
// Accepted numbers wait in a two-entry queue, so the next beat is taken while
// the current one is still being divided or sent out.
// When m_axis_tready is low the character on the output is held, the back end
// stops, the queue fills and s_axis_tready then falls.
// Reset clears the queue, the sequencer and the output valid; there is no
// clearing pass, the block takes beats in the first cycle after reset.
module integer_to_ascii_radix #(
    parameter int VALUE_BITS = 32
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // value, radix, zero fill
    input  logic [((VALUE_BITS + itar_pkg::RADIX_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // signed_mode
    input  logic s_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // character
    output logic [itar_pkg::CHAR_BITS-1:0] m_axis_tdata,
    output logic m_axis_tlast
);

    import itar_pkg::*;

    `include "integer_to_ascii_radix_macros.svh"

    localparam int Q_WIDTH = VALUE_BITS + $bits(item_ctl_t);

    logic                  q_push, q_full, q_pop, q_empty;
    logic [VALUE_BITS-1:0] f_magnitude, b_magnitude;
    item_ctl_t             f_ctl, b_ctl;
    logic [Q_WIDTH-1:0]    q_head;
    div_req_t              div_req;
    logic [VALUE_BITS-1:0] div_dividend, div_quotient;
    logic [RADIX_BITS-1:0] div_remainder;
    logic                  div_done;
    logic                  out_minus;
    logic                  out_char_ok;
    logic                  minus_shown;
    logic                  minus_taken;
    logic                  digit_shown;

    itar_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .value       (s_axis_tdata[VALUE_BITS-1:0]),
        .radix       (s_axis_tdata[VALUE_BITS +: RADIX_BITS]),
        .signed_mode (s_axis_tuser),
        .full        (q_full),
        .push        (q_push),
        .magnitude   (f_magnitude),
        .ctl         (f_ctl)
    );

    itar_fifo #(
        .WIDTH (Q_WIDTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({f_ctl, f_magnitude}),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_head),
        .empty     (q_empty)
    );

    assign b_magnitude = q_head[VALUE_BITS-1:0];
    assign b_ctl       = q_head[Q_WIDTH-1:VALUE_BITS];

    itar_div #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (div_req),
        .dividend  (div_dividend),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    itar_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .empty         (q_empty),
        .pop           (q_pop),
        .magnitude     (b_magnitude),
        .ctl           (b_ctl),
        .div_req       (div_req),
        .div_dividend  (div_dividend),
        .div_done      (div_done),
        .div_quotient  (div_quotient),
        .div_remainder (div_remainder),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_char      (m_axis_tdata),
        .out_last      (m_axis_tlast)
    );

    assign out_minus   = (m_axis_tdata == CHAR_MINUS);
    assign out_char_ok = out_minus
        || ((m_axis_tdata >= CHAR_ZERO) && (m_axis_tdata <= CHAR_ZERO + 8'd9))
        || ((m_axis_tdata >= CHAR_LOWER_A) && (m_axis_tdata <= CHAR_LOWER_A + 8'd25));
    assign minus_shown = m_axis_tvalid && out_minus;
    assign minus_taken = minus_shown && m_axis_tready;
    assign digit_shown = m_axis_tvalid && !out_minus;

    `ITAR_ASSERT_NOW(a_push_room, q_push, !q_full, "push into a full queue")

    `ITAR_ASSERT_NOW(a_minus_not_last, minus_shown, !m_axis_tlast, "minus sign marked last")

    `ITAR_ASSERT_NEXT(a_digit_after_minus, minus_taken, digit_shown, "no digit after minus")

    `ITAR_ASSERT_NOW(a_char_set, m_axis_tvalid, out_char_ok, "character outside the digit set")

endmodule
